// ----- rtl/prnc_pkg.sv -----
// package: block width, cipher tables and the round layer functions
package prnc_pkg;

  localparam int BLOCK_W         = 64;
  localparam int HALF_ROUNDS_W   = 3;
  localparam int MAX_HALF_ROUNDS = 5;
  localparam int NUM_RC          = 12;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'hb, 4'hf, 4'h3, 4'h2, 4'ha, 4'hc, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'he, 4'h5, 4'hd, 4'h4
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'hb, 4'h7, 4'h3, 4'h2, 4'hf, 4'hd, 4'h8, 4'h9,
    4'ha, 4'h6, 4'h4, 4'h0, 4'h5, 4'he, 4'hc, 4'h1
  };
  localparam logic [3:0] ROWS_FWD [16] = '{
    4'd4, 4'd9, 4'd14, 4'd3, 4'd8, 4'd13, 4'd2, 4'd7,
    4'd12, 4'd1, 4'd6, 4'd11, 4'd0, 4'd5, 4'd10, 4'd15
  };
  localparam logic [3:0] ROWS_INV [16] = '{
    4'd12, 4'd9, 4'd6, 4'd3, 4'd0, 4'd13, 4'd10, 4'd7,
    4'd4, 4'd1, 4'd14, 4'd11, 4'd8, 4'd5, 4'd2, 4'd15
  };
  localparam logic [BLOCK_W-1:0] ROUND_CONST [NUM_RC] = '{
    64'h0000000000000000, 64'h13198a2e03707344, 64'ha4093822299f31d0,
    64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
    64'h7ef84f78fd955cb1, 64'h85840851f1ac43aa, 64'hc882d32f25323c54,
    64'h64a51195e0e3610d, 64'hd3b5a399ca0c2399, 64'hc0ac29b7c97c50dd
  };
  localparam logic [15:0] MIX_MASKS [4] = '{16'h7bde, 16'hbde7, 16'hde7b, 16'he7bd};

  // nibble-wise forward s-box
  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_FWD[x[4*i +: 4]];
    end
    return r;
  endfunction

  // nibble-wise inverse s-box
  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = SBOX_INV[x[4*i +: 4]];
    end
    return r;
  endfunction

  // xor of the four nibbles of a 16-bit word
  function automatic logic [3:0] fold_nibbles(input logic [15:0] v);
    return v[3:0] ^ v[7:4] ^ v[11:8] ^ v[15:12];
  endfunction

  // m-prime linear layer, four 16-bit columns
  function automatic logic [BLOCK_W-1:0] mix_prime(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    logic [15:0]        word;
    logic [1:0]         m;
    r = '0;
    for (int b = 0; b < 4; b++) begin
      word = x[16*b +: 16];
      for (int n = 0; n < 4; n++) begin
        m = 2'(((b == 0 || b == 3) ? 0 : 1) + 3 - n);
        r[16*b + 4*n +: 4] = fold_nibbles(word & MIX_MASKS[m]);
      end
    end
    return r;
  endfunction

  // forward row shift
  function automatic logic [BLOCK_W-1:0] rows_fwd(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = x[4*ROWS_FWD[i] +: 4];
    end
    return r;
  endfunction

  // inverse row shift
  function automatic logic [BLOCK_W-1:0] rows_inv(input logic [BLOCK_W-1:0] x);
    logic [BLOCK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[4*i +: 4] = x[4*ROWS_INV[i] +: 4];
    end
    return r;
  endfunction

endpackage

// ----- rtl/prnc_round.sv -----
// one registered round stage, forward or inverse, with bypass when not active
module prnc_round (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         inverse,
  input  logic                         active,
  input  logic [prnc_pkg::BLOCK_W-1:0] round_key,
  input  logic                         in_valid,
  input  logic [prnc_pkg::BLOCK_W-1:0] in_data,
  output logic                         out_valid,
  output logic [prnc_pkg::BLOCK_W-1:0] out_data
);
  import prnc_pkg::*;

  logic [BLOCK_W-1:0] fwd_res;
  logic [BLOCK_W-1:0] inv_res;
  logic [BLOCK_W-1:0] round_res;

  // forward: s-box, m-prime, row shift, key add
  assign fwd_res = rows_fwd(mix_prime(sub_fwd(in_data))) ^ round_key;
  // inverse: key add, inverse row shift, m-prime, inverse s-box
  assign inv_res = sub_inv(mix_prime(rows_inv(in_data ^ round_key)));

  // pick the direction, or pass through when the round is skipped
  always_comb begin
    if (!active) begin
      round_res = in_data;
    end else if (inverse) begin
      round_res = inv_res;
    end else begin
      round_res = fwd_res;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= round_res;
  end

endmodule

// ----- rtl/prince_block_encrypt_core.sv -----
// top level: pipelined 64-bit block encipherment with configurable round count
//
// Takes one 64-bit block per clock (start while busy is low; busy never rises)
// and returns the enciphered block on cipher_block, marked by a one-cycle done
// strobe. The pipeline holds one whitening stage, five forward round stages,
// the middle layer, five inverse round stages and the output whitening
// register; rounds beyond half_rounds are bypassed inside their stage, so
// latency does not depend on the round count. The receiver cannot stall and
// results are never held. Key halves and half_rounds are written through
// wr_en/wr_index/wr_data (index 0 key_high, 1 key_low, 2 half_rounds, whose
// low three bits are taken and saturate above five) and must only change
// while no transaction is in flight.
module prince_block_encrypt_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [prnc_pkg::BLOCK_W-1:0] plain_block,
  output logic                         done,
  output logic [prnc_pkg::BLOCK_W-1:0] cipher_block,
  input  logic                         wr_en,
  input  logic [1:0]                   wr_index,
  input  logic [prnc_pkg::BLOCK_W-1:0] wr_data
);
  import prnc_pkg::*;

  localparam logic [1:0] REG_KEY_HIGH    = 2'd0;
  localparam logic [1:0] REG_KEY_LOW     = 2'd1;
  localparam logic [1:0] REG_HALF_ROUNDS = 2'd2;
  localparam logic [HALF_ROUNDS_W-1:0] HALF_ROUNDS_SAT = HALF_ROUNDS_W'(MAX_HALF_ROUNDS);

  logic [BLOCK_W-1:0]       key_high;
  logic [BLOCK_W-1:0]       key_low;
  logic [HALF_ROUNDS_W-1:0] half_rounds;
  logic [BLOCK_W-1:0]       key_prime;

  logic                     fwd_valid [MAX_HALF_ROUNDS+1];
  logic [BLOCK_W-1:0]       fwd_data  [MAX_HALF_ROUNDS+1];
  logic                     inv_valid [MAX_HALF_ROUNDS+1];
  logic [BLOCK_W-1:0]       inv_data  [MAX_HALF_ROUNDS+1];

  assign busy = 1'b0;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high    <= '0;
      key_low     <= '0;
      half_rounds <= HALF_ROUNDS_SAT;
    end else if (wr_en) begin
      case (wr_index)
        REG_KEY_HIGH:    key_high <= wr_data;
        REG_KEY_LOW:     key_low  <= wr_data;
        REG_HALF_ROUNDS: begin
          if (wr_data[HALF_ROUNDS_W-1:0] > HALF_ROUNDS_SAT) begin
            half_rounds <= HALF_ROUNDS_SAT;
          end else begin
            half_rounds <= wr_data[HALF_ROUNDS_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output whitening key: high half rotated right by one, msb folded into bit 0
  assign key_prime = {key_high[0], key_high[BLOCK_W-1:1]} ^
                     {{(BLOCK_W-1){1'b0}}, key_high[BLOCK_W-1]};

  // input whitening stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid[0] <= 1'b0;
    end else begin
      fwd_valid[0] <= start && !busy;
    end
    fwd_data[0] <= plain_block ^ key_high ^ key_low ^ ROUND_CONST[0];
  end

  // forward rounds, round constant index 1..5, odd ones use key_high
  for (genvar g = 0; g < MAX_HALF_ROUNDS; g++) begin : g_fwd
    logic [BLOCK_W-1:0] rk;
    logic               act;
    assign rk  = ROUND_CONST[g+1] ^ (((g + 1) % 2 == 1) ? key_high : key_low);
    assign act = half_rounds > HALF_ROUNDS_W'(g);
    prnc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .inverse   (1'b0),
      .active    (act),
      .round_key (rk),
      .in_valid  (fwd_valid[g]),
      .in_data   (fwd_data[g]),
      .out_valid (fwd_valid[g+1]),
      .out_data  (fwd_data[g+1])
    );
  end

  // middle layer: s-box, m-prime, inverse s-box
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid[0] <= 1'b0;
    end else begin
      inv_valid[0] <= fwd_valid[MAX_HALF_ROUNDS];
    end
    inv_data[0] <= sub_inv(mix_prime(sub_fwd(fwd_data[MAX_HALF_ROUNDS])));
  end

  // inverse rounds, round constant index 6..10, active for the last half_rounds
  for (genvar g = 0; g < MAX_HALF_ROUNDS; g++) begin : g_inv
    logic [BLOCK_W-1:0] rk;
    logic               act;
    assign rk  = ROUND_CONST[g+6] ^ (((g + 6) % 2 == 1) ? key_low : key_high);
    assign act = half_rounds >= HALF_ROUNDS_W'(MAX_HALF_ROUNDS - g);
    prnc_round u_round (
      .clk       (clk),
      .rst       (rst),
      .inverse   (1'b1),
      .active    (act),
      .round_key (rk),
      .in_valid  (inv_valid[g]),
      .in_data   (inv_data[g]),
      .out_valid (inv_valid[g+1]),
      .out_data  (inv_data[g+1])
    );
  end

  // output whitening and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= inv_valid[MAX_HALF_ROUNDS];
    end
    cipher_block <= inv_data[MAX_HALF_ROUNDS] ^ ROUND_CONST[NUM_RC-1] ^ key_low ^ key_prime;
  end

  // every result traces back to a transaction accepted a full pipeline earlier
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 13))
    else $error("result without matching transaction");

  // the last inverse stage always produces a result in the next cycle
  a_last_to_done: assert property (@(posedge clk) disable iff (rst)
    inv_valid[MAX_HALF_ROUNDS] |=> done)
    else $error("result dropped at output");

  // middle stage feeds the inverse chain in the next cycle
  a_mid_valid: assert property (@(posedge clk) disable iff (rst)
    fwd_valid[MAX_HALF_ROUNDS] |=> inv_valid[0])
    else $error("item lost at middle layer");

  // round count saturates
  a_half_rounds_sat: assert property (@(posedge clk) disable iff (rst)
    half_rounds <= HALF_ROUNDS_SAT)
    else $error("half_rounds out of range");

endmodule
